>>> hw/rtl/lfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types, constants and the microcode program of the LED fade driver.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int LevelW     = 7;
    localparam int TimeW      = 16;
    localparam int QuotW      = 10;             // quotients stay below 1024
    localparam int ProdW      = TimeW + QuotW;  // elapsed * 1000 fits here
    localparam int CntW       = 4;
    localparam int PcW        = 4;
    localparam int OpW        = 4;
    localparam int CondW      = 3;
    localparam int RecipW     = 17;             // delta * progress stays below 2^17
    localparam int RecipShift = 26;

    localparam logic [LevelW-1:0] LevelFull = 7'd100;
    localparam logic [QuotW-1:0]  Permille  = 10'd1000;
    // 2^26 / 1000 rounded up, exact division by 1000 for inputs below 2^17
    localparam logic [RecipW-1:0] Recip     = 17'd67109;

    typedef struct packed {
        logic              command;
        logic [LevelW-1:0] level;
        logic [TimeW-1:0]  fade_ms;
    } in_t;

    typedef struct packed {
        logic              led_level;
        logic [LevelW-1:0] shown_level;
    } out_t;

    // datapath operations
    localparam logic [OpW-1:0] OP_NOP          = 4'd0;
    localparam logic [OpW-1:0] OP_FETCH        = 4'd1;
    localparam logic [OpW-1:0] OP_SET          = 4'd2;
    localparam logic [OpW-1:0] OP_STOP         = 4'd3;
    localparam logic [OpW-1:0] OP_ELAPSE       = 4'd4;
    localparam logic [OpW-1:0] OP_MUL_FADE     = 4'd5;
    localparam logic [OpW-1:0] OP_DIV_LOAD_LEN = 4'd6;
    localparam logic [OpW-1:0] OP_DIV_STEP     = 4'd7;
    localparam logic [OpW-1:0] OP_MUL_DELTA    = 4'd8;
    localparam logic [OpW-1:0] OP_SCALE        = 4'd9;
    localparam logic [OpW-1:0] OP_APPLY        = 4'd10;
    localparam logic [OpW-1:0] OP_FINISH       = 4'd11;
    localparam logic [OpW-1:0] OP_DITHER       = 4'd12;

    // jump conditions
    localparam logic [CondW-1:0] C_NEVER    = 3'd0;
    localparam logic [CondW-1:0] C_NO_REQ   = 3'd1;
    localparam logic [CondW-1:0] C_SET      = 3'd2;
    localparam logic [CondW-1:0] C_IDLE     = 3'd3;
    localparam logic [CondW-1:0] C_DONE     = 3'd4;
    localparam logic [CondW-1:0] C_DIV_MORE = 3'd5;
    localparam logic [CondW-1:0] C_OUT_BUSY = 3'd6;
    localparam logic [CondW-1:0] C_ALWAYS   = 3'd7;

    // program addresses
    localparam logic [PcW-1:0] ST_FETCH    = 4'd0;
    localparam logic [PcW-1:0] ST_DECODE   = 4'd1;
    localparam logic [PcW-1:0] ST_CHECK    = 4'd2;
    localparam logic [PcW-1:0] ST_ELAPSE   = 4'd3;
    localparam logic [PcW-1:0] ST_TEST_END = 4'd4;
    localparam logic [PcW-1:0] ST_MUL_FADE = 4'd5;
    localparam logic [PcW-1:0] ST_LOAD_LEN = 4'd6;
    localparam logic [PcW-1:0] ST_DIV_A    = 4'd7;
    localparam logic [PcW-1:0] ST_MUL_DLT  = 4'd8;
    localparam logic [PcW-1:0] ST_SCALE    = 4'd9;
    localparam logic [PcW-1:0] ST_APPLY    = 4'd10;
    localparam logic [PcW-1:0] ST_FINISH   = 4'd11;
    localparam logic [PcW-1:0] ST_DITHER   = 4'd12;
    localparam logic [PcW-1:0] ST_RETURN   = 4'd13;
    localparam logic [PcW-1:0] ST_SET      = 4'd14;
    localparam logic [PcW-1:0] ST_STOP     = 4'd15;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [CondW-1:0] cond;
        logic [PcW-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic no_req;
        logic is_set;
        logic idle_tick;
        logic done;
        logic div_more;
        logic out_busy;
    } stat_t;

    // control store: taken branch goes to target, otherwise to the next step
    function automatic ctrl_t ucode_word(input logic [PcW-1:0] pc);
        ctrl_t w;
        unique case (pc)
            ST_FETCH:    w = '{OP_FETCH,        C_NO_REQ,   ST_FETCH};
            ST_DECODE:   w = '{OP_NOP,          C_SET,      ST_SET};
            ST_CHECK:    w = '{OP_NOP,          C_IDLE,     ST_STOP};
            ST_ELAPSE:   w = '{OP_ELAPSE,       C_NEVER,    ST_FETCH};
            ST_TEST_END: w = '{OP_NOP,          C_DONE,     ST_FINISH};
            ST_MUL_FADE: w = '{OP_MUL_FADE,     C_NEVER,    ST_FETCH};
            ST_LOAD_LEN: w = '{OP_DIV_LOAD_LEN, C_NEVER,    ST_FETCH};
            ST_DIV_A:    w = '{OP_DIV_STEP,     C_DIV_MORE, ST_DIV_A};
            ST_MUL_DLT:  w = '{OP_MUL_DELTA,    C_NEVER,    ST_FETCH};
            ST_SCALE:    w = '{OP_SCALE,        C_NEVER,    ST_FETCH};
            ST_APPLY:    w = '{OP_APPLY,        C_ALWAYS,   ST_DITHER};
            ST_FINISH:   w = '{OP_FINISH,       C_NEVER,    ST_FETCH};
            ST_DITHER:   w = '{OP_DITHER,       C_OUT_BUSY, ST_DITHER};
            ST_RETURN:   w = '{OP_NOP,          C_ALWAYS,   ST_FETCH};
            ST_SET:      w = '{OP_SET,          C_ALWAYS,   ST_FETCH};
            ST_STOP:     w = '{OP_STOP,         C_ALWAYS,   ST_FETCH};
            default:     w = '{OP_NOP,          C_ALWAYS,   ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/led_fade_dither_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_fade_dither_driver_unit
// LED brightness fade with first-order accumulator dither, microcoded control.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per item, either a set command (target level
// and fade time) or a timer tick. Result channel m_*: one item per tick that
// advances a fade, carrying the LED pin value and the level shown. Set
// commands and idle ticks give no result. cfg_we/cfg_wdata write the tick
// interval in milliseconds, taking effect on the next tick.
// A tick inside a fade runs the 10-step serial divider that forms the per-mille
// progress (the divide by 1000 is one reciprocal multiply step); a tick that ends
// a fade skips it. No new request is taken until the current one is through.
// The output register holds a finished result while the next request is
// accepted; if a second result is ready before the first is taken, the
// sequencer waits in its dither step until m_ready frees the register.
// Reset clears all fade state, the dither accumulator, the tick interval and
// the output valid, and starts the program at its fetch step.
// ----------------------------------------------------------------------------
module led_fade_dither_driver_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [lfd_pkg::TimeW-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lfd_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lfd_pkg::out_t             m_data
);

    lfd_pkg::ctrl_t ctrl;
    lfd_pkg::stat_t stat;

    lfd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    lfd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hw/rtl/lfd_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_sequencer
// Step counter and control store; picks the next step from the datapath flags.
// ----------------------------------------------------------------------------
module lfd_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  lfd_pkg::stat_t stat,
    output lfd_pkg::ctrl_t ctrl
);

    logic [lfd_pkg::PcW-1:0] pc_reg;
    logic [lfd_pkg::PcW-1:0] pc_next;
    logic                    taken;

    assign ctrl = lfd_pkg::ucode_word(pc_reg);

    always_comb begin
        case (ctrl.cond)
            lfd_pkg::C_NEVER:    taken = 1'b0;
            lfd_pkg::C_NO_REQ:   taken = stat.no_req;
            lfd_pkg::C_SET:      taken = stat.is_set;
            lfd_pkg::C_IDLE:     taken = stat.idle_tick;
            lfd_pkg::C_DONE:     taken = stat.done;
            lfd_pkg::C_DIV_MORE: taken = stat.div_more;
            lfd_pkg::C_OUT_BUSY: taken = stat.out_busy;
            lfd_pkg::C_ALWAYS:   taken = 1'b1;
            default:             taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= lfd_pkg::ST_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hw/rtl/lfd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_datapath
// Fade state, multipliers and serial divider, dither and output register.
// ----------------------------------------------------------------------------
module lfd_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lfd_pkg::ctrl_t           ctrl,
    output lfd_pkg::stat_t           stat,
    input  logic                     cfg_we,
    input  logic [lfd_pkg::TimeW-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lfd_pkg::in_t             s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lfd_pkg::out_t            m_data
);

    localparam int LW = lfd_pkg::LevelW;
    localparam int TW = lfd_pkg::TimeW;
    localparam int QW = lfd_pkg::QuotW;
    localparam int PW = lfd_pkg::ProdW;
    localparam int CW = lfd_pkg::CntW;
    localparam int RW = lfd_pkg::RecipW;

    logic [TW-1:0]  interval_reg, interval_next;
    lfd_pkg::in_t   in_reg, in_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [LW-1:0]  tgt_reg, tgt_next;
    logic [TW-1:0]  flen_reg, flen_next;
    logic [TW-1:0]  elapsed_reg, elapsed_next;
    logic           fading_reg, fading_next;
    logic [7:0]     dsum_reg, dsum_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [PW-1:0]  dsh_reg, dsh_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           m_valid_reg, m_valid_next;
    lfd_pkg::out_t  m_data_reg, m_data_next;

    logic           accept;
    logic           out_busy;
    logic           up;
    logic [LW-1:0]  delta;
    logic [LW-1:0]  lvl_sat;
    logic [TW:0]    elapsed_sum;
    logic [LW:0]    cur_adj;
    logic [8:0]     dither_sum;
    logic           led_on;
    logic [2*RW-1:0] scaled;

    assign s_ready  = (ctrl.op == lfd_pkg::OP_FETCH);
    assign accept   = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign stat.no_req    = !accept;
    assign stat.is_set    = in_reg.command;
    assign stat.idle_tick = !fading_reg || (cur_reg == tgt_reg);
    assign stat.done      = (elapsed_reg >= flen_reg);
    assign stat.div_more  = (cnt_reg != CW'(1));
    assign stat.out_busy  = out_busy;

    always_comb begin
        up          = (tgt_reg >= cur_reg);
        delta       = up ? tgt_reg - cur_reg : cur_reg - tgt_reg;
        lvl_sat     = (in_reg.level > lfd_pkg::LevelFull) ? lfd_pkg::LevelFull : in_reg.level;
        elapsed_sum = {1'b0, elapsed_reg} + {1'b0, interval_reg};
        cur_adj     = up ? {1'b0, cur_reg} + {1'b0, q_reg[LW-1:0]}
                         : {1'b0, cur_reg} - {1'b0, q_reg[LW-1:0]};
        dither_sum  = {1'b0, dsum_reg} + {2'b00, cur_reg};
        led_on      = (dither_sum >= {2'b00, lfd_pkg::LevelFull});
        scaled      = (2*RW)'(prod_reg[RW-1:0]) * (2*RW)'(lfd_pkg::Recip);

        interval_next = cfg_we ? cfg_wdata : interval_reg;
        in_next       = in_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        flen_next     = flen_reg;
        elapsed_next  = elapsed_reg;
        fading_next   = fading_reg;
        dsum_next     = dsum_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (ctrl.op)
            lfd_pkg::OP_NOP: begin
            end
            lfd_pkg::OP_FETCH: begin
                if (accept) begin
                    in_next = s_data;
                end
            end
            lfd_pkg::OP_SET: begin
                tgt_next = lvl_sat;
                if (in_reg.fade_ms == '0) begin
                    cur_next    = lvl_sat;
                    fading_next = 1'b0;
                end else begin
                    flen_next    = in_reg.fade_ms;
                    elapsed_next = '0;
                    fading_next  = 1'b1;
                end
            end
            lfd_pkg::OP_STOP: begin
                fading_next = 1'b0;
            end
            lfd_pkg::OP_ELAPSE: begin
                elapsed_next = elapsed_sum[TW] ? {TW{1'b1}} : elapsed_sum[TW-1:0];
            end
            lfd_pkg::OP_MUL_FADE: begin
                prod_next = PW'(elapsed_reg) * PW'(lfd_pkg::Permille);
            end
            lfd_pkg::OP_DIV_LOAD_LEN: begin
                // quotient below 2^QW, so the divisor starts QW-1 places up
                acc_next = prod_reg;
                dsh_next = PW'(flen_reg) << (QW - 1);
                cnt_next = CW'(QW);
            end
            lfd_pkg::OP_DIV_STEP: begin
                if (acc_reg >= dsh_reg) begin
                    acc_next = acc_reg - dsh_reg;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end else begin
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            lfd_pkg::OP_MUL_DELTA: begin
                prod_next = PW'(delta) * PW'(q_reg);
            end
            lfd_pkg::OP_SCALE: begin
                // divide by 1000 as a multiply by the rounded-up reciprocal
                q_next = QW'(scaled[2*RW-1:lfd_pkg::RecipShift]);
            end
            lfd_pkg::OP_APPLY: begin
                cur_next = (cur_adj > {1'b0, lfd_pkg::LevelFull}) ? lfd_pkg::LevelFull
                                                                   : cur_adj[LW-1:0];
            end
            lfd_pkg::OP_FINISH: begin
                cur_next    = tgt_reg;
                fading_next = 1'b0;
            end
            lfd_pkg::OP_DITHER: begin
                // held until the output register is free
                if (!out_busy) begin
                    dsum_next    = led_on ? 8'(dither_sum - {2'b00, lfd_pkg::LevelFull})
                                          : dither_sum[7:0];
                    m_valid_next = 1'b1;
                    m_data_next  = '{led_level: led_on, shown_level: cur_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= '0;
            cur_reg      <= '0;
            tgt_reg      <= '0;
            flen_reg     <= '0;
            elapsed_reg  <= '0;
            fading_reg   <= 1'b0;
            dsum_reg     <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            interval_reg <= interval_next;
            cur_reg      <= cur_next;
            tgt_reg      <= tgt_next;
            flen_reg     <= flen_next;
            elapsed_reg  <= elapsed_next;
            fading_reg   <= fading_next;
            dsum_reg     <= dsum_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= lfd_pkg::LevelFull && tgt_reg <= lfd_pkg::LevelFull)
        else $error("level left 0..100");

    a_dither_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dsum_reg < 8'(lfd_pkg::LevelFull))
        else $error("dither accumulator out of range");

    a_dither_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == lfd_pkg::OP_DITHER && out_busy) |=> $stable(dsum_reg))
        else $error("dither advanced while output stalled");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == lfd_pkg::OP_DIV_STEP) |-> (cnt_reg != '0))
        else $error("divider step with empty count");
`endif

endmodule
